// ===== rtl/cpli_pkg.sv =====
// shared types and constants for the piecewise-linear sensor linearizer
// no dependencies; used by cpli_muldiv, clamped_piecewise_linear_interp and the testbench
package cpli_pkg;

  localparam int DATA_W         = 32;   // q16.16 value width
  localparam int CFG_W          = 5;    // active_points register width
  localparam int IDX_W          = 4;    // point_index field width
  localparam int MAX_POINTS_DEF = 16;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd2;

  // action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // operands for the serial multiply/divide: mag * dq / dx, all unsigned
  typedef struct packed {
    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] dq;
    logic [DATA_W-1:0] dx;
  } md_req_t;

endpackage

// ===== rtl/cpli_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module cpli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/cpli_muldiv.sv =====
// bit-serial unsigned mag * dq / dx: 32 shift-add steps, then 32 restoring divide steps
// depends on cpli_pkg; the quotient must fit in DATA_W bits (dq < dx)
module cpli_muldiv (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             go,
  input  cpli_pkg::md_req_t                req,
  output logic                             done,
  output logic [cpli_pkg::DATA_W-1:0]      quot
);

  localparam int W  = cpli_pkg::DATA_W;
  localparam int CW = $clog2(W);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  logic [1:0]    phase;
  logic [CW-1:0] cnt;
  logic [W-1:0]  hi;
  logic [W-1:0]  lo;
  logic [W-1:0]  mag;
  logic [W-1:0]  dx;

  logic [W:0]    sum;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;

  always_comb begin
    sum   = {1'b0, hi} + (lo[0] ? {1'b0, mag} : {(W+1){1'b0}});
    trial = {hi, lo[W-1]};
    diff  = trial - {1'b0, dx};
    ge    = trial >= {1'b0, dx};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (go) begin
            phase <= PH_MUL;
            cnt   <= '0;
          end
        end
        PH_MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(W - 1)) begin
            phase <= PH_DIV;
          end
        end
        PH_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(W - 1)) begin
            phase <= PH_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

  // product accumulates in {hi, lo}; the divide then reuses hi as remainder
  // and shifts quotient bits into lo
  always_ff @(posedge clk) begin
    case (phase)
      PH_IDLE: begin
        if (go) begin
          hi  <= '0;
          lo  <= req.dq;
          mag <= req.mag;
          dx  <= req.dx;
        end
      end
      PH_MUL: begin
        hi <= sum[W:1];
        lo <= {sum[0], lo[W-1:1]};
      end
      PH_DIV: begin
        hi <= ge ? diff[W-1:0] : trial[W-1:0];
        lo <= {lo[W-2:0], ge};
      end
      default: begin
        hi <= hi;
      end
    endcase
  end

  assign quot = lo;

endmodule

// ===== rtl/clamped_piecewise_linear_interp.sv =====
// clamped piecewise-linear sensor linearizer, q16.16 signed
// depends on cpli_pkg, cpli_ram (breakpoint table) and cpli_muldiv (serial mul/div)
//
// usage:
//   an item is taken at a clock edge with start high and busy low.
//   action = load writes breakpoint (point_x, point_y) into entry point_index
//   and gives no result; busy stays low. indexes at or above MAX_POINTS
//   are dropped.
//   action = query converts query_x. busy rises for the whole query; the
//   result appears on converted_value for exactly one cycle with done high.
//   the receiver has no way to stall, so each result beat must be taken then.
//   the table walk reads one entry per cycle from the single read port; the
//   interpolation then runs 32 shift-add steps and 32 restoring divide steps,
//   one bit per cycle.
//   a new item may be started in the cycle that done is high.
//   cfg_we writes active_points (values below 2 act as 2, above MAX_POINTS as
//   MAX_POINTS); write it only while idle.
//   reset (rst, synchronous) sets active_points to 2 and drops any query in
//   flight; the table contents are undefined until loaded.
module clamped_piecewise_linear_interp #(
  parameter int MAX_POINTS = cpli_pkg::MAX_POINTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  action,
  input  logic        [cpli_pkg::IDX_W-1:0]     point_index,
  input  logic signed [cpli_pkg::DATA_W-1:0]    point_x,
  input  logic signed [cpli_pkg::DATA_W-1:0]    point_y,
  input  logic signed [cpli_pkg::DATA_W-1:0]    query_x,
  input  logic                                  cfg_we,
  input  logic        [cpli_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                                  done,
  output logic signed [cpli_pkg::DATA_W-1:0]    converted_value
);

  localparam int W   = cpli_pkg::DATA_W;
  localparam int AW  = $clog2(MAX_POINTS);
  localparam int NW  = $clog2(MAX_POINTS + 1);
  localparam int CW  = (cpli_pkg::CFG_W > NW) ? cpli_pkg::CFG_W : NW;
  localparam int LW  = (cpli_pkg::IDX_W > NW) ? cpli_pkg::IDX_W : NW;

  localparam logic [CW-1:0] MAXP_C = CW'(MAX_POINTS);
  localparam logic [CW-1:0] MINP_C = CW'(2);
  localparam logic [LW-1:0] MAXP_L = LW'(MAX_POINTS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_CALC  = 2'd3;

  logic [1:0]                 state;
  logic [cpli_pkg::CFG_W-1:0] active_points;
  logic [AW-1:0]              nlast;
  logic [AW-1:0]              rd_idx;
  logic                       data_valid;
  logic [AW-1:0]              data_idx;
  logic                       found;
  logic                       below;
  logic                       md_go;

  logic signed [W-1:0]        q;
  logic signed [W-1:0]        prev_x;
  logic signed [W-1:0]        prev_y;
  logic signed [W-1:0]        first_y;
  logic signed [W-1:0]        seg_y0;
  logic                       seg_neg;
  cpli_pkg::md_req_t          seg_req;

  logic                       accept;
  logic                       load_we;
  logic [CW-1:0]              ap_ext;
  logic [CW-1:0]              n_used;
  logic [2*W-1:0]             rd_data;
  logic signed [W-1:0]        cur_x;
  logic signed [W-1:0]        cur_y;
  logic                       match;
  logic signed [W:0]          dq_w;
  logic signed [W:0]          dx_w;
  logic signed [W:0]          dy_w;
  logic [W:0]                 mag_w;
  logic                       md_done;
  logic [W-1:0]               quot;

  assign accept  = start && !busy;
  assign load_we = accept && (action == cpli_pkg::ACT_LOAD)
                   && (LW'(point_index) < MAXP_L);
  assign busy    = (state != S_IDLE);

  always_comb begin
    ap_ext = CW'(active_points);
    if (ap_ext < MINP_C) begin
      n_used = MINP_C;
    end else if (ap_ext > MAXP_C) begin
      n_used = MAXP_C;
    end else begin
      n_used = ap_ext;
    end
  end

  cpli_ram #(
    .WIDTH (2 * W),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (load_we),
    .waddr (AW'(point_index)),
    .wdata ({point_x, point_y}),
    .re    (state == S_SCAN),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  always_comb begin
    cur_x = signed'(rd_data[2*W-1:W]);
    cur_y = signed'(rd_data[W-1:0]);
    match = (prev_x <= q) && (q < cur_x);
    dq_w  = {q[W-1], q} - {prev_x[W-1], prev_x};
    dx_w  = {cur_x[W-1], cur_x} - {prev_x[W-1], prev_x};
    dy_w  = {cur_y[W-1], cur_y} - {prev_y[W-1], prev_y};
    mag_w = dy_w[W] ? (~dy_w + 1'b1) : dy_w;
  end

  cpli_muldiv u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .go   (md_go),
    .req  (seg_req),
    .done (md_done),
    .quot (quot)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      active_points <= cpli_pkg::ACTIVE_RESET;
      rd_idx        <= '0;
      data_valid    <= 1'b0;
      found         <= 1'b0;
      md_go         <= 1'b0;
      done          <= 1'b0;
    end else begin
      done       <= 1'b0;
      md_go      <= 1'b0;
      data_valid <= (state == S_SCAN);
      if (cfg_we) begin
        active_points <= cfg_wdata;
      end
      if (data_valid && (data_idx != '0) && !found && match) begin
        found <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept && (action == cpli_pkg::ACT_QUERY)) begin
            state  <= S_SCAN;
            rd_idx <= '0;
            found  <= 1'b0;
          end
        end
        S_SCAN: begin
          if (rd_idx == nlast) begin
            state <= S_DRAIN;
          end else begin
            rd_idx <= rd_idx + 1'b1;
          end
        end
        S_DRAIN: begin
          // last entry is on the read port now
          if (!below && (q < cur_x) && (found || match)) begin
            state <= S_CALC;
            md_go <= 1'b1;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_CALC: begin
          if (md_done) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    data_idx <= rd_idx;
    if (accept && (action == cpli_pkg::ACT_QUERY)) begin
      q     <= query_x;
      nlast <= AW'(n_used - 1'b1);
    end
    if (data_valid) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
      if (data_idx == '0) begin
        below   <= (q <= cur_x);
        first_y <= cur_y;
      end else if (!found && match) begin
        seg_y0      <= prev_y;
        seg_neg     <= dy_w[W];
        seg_req.mag <= mag_w[W-1:0];
        seg_req.dq  <= dq_w[W-1:0];
        seg_req.dx  <= dx_w[W-1:0];
      end
    end
    if (state == S_DRAIN) begin
      converted_value <= below ? first_y : cur_y;
    end else if ((state == S_CALC) && md_done) begin
      converted_value <= seg_neg ? (seg_y0 - signed'(quot)) : (seg_y0 + signed'(quot));
    end
  end

endmodule

// ===== test/clamped_piecewise_linear_interp_tb.sv =====
// self-checking testbench for the clamped piecewise-linear sensor linearizer
// depends on cpli_pkg and clamped_piecewise_linear_interp; predicts every result
// from its own copy of the breakpoint table and compares it beat by beat
`timescale 1ns / 100ps

module clamped_piecewise_linear_interp_tb;

  localparam int DATA_W = cpli_pkg::DATA_W;
  localparam int IDX_W  = cpli_pkg::IDX_W;
  localparam int CFG_W  = cpli_pkg::CFG_W;

  localparam int POINTS = cpli_pkg::MAX_POINTS_DEF;
  localparam int RANDOM_ITEMS = 1200;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic signed [DATA_W-1:0] reading;
    logic signed [DATA_W-1:0] value;
  } conversion_t;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic                     action;
  logic        [IDX_W-1:0]  point_index;
  logic signed [DATA_W-1:0] point_x;
  logic signed [DATA_W-1:0] point_y;
  logic signed [DATA_W-1:0] query_x;
  logic                     cfg_we;
  logic        [CFG_W-1:0]  cfg_wdata;
  logic                     done;
  logic signed [DATA_W-1:0] converted_value;

  // predictor state
  logic signed [DATA_W-1:0] bp_x [POINTS];
  logic signed [DATA_W-1:0] bp_y [POINTS];
  logic        [CFG_W-1:0]  active_cfg;

  conversion_t pending_conversions[$];
  int          mismatch_count = 0;
  int          items_sent = 0;
  bit          sender_gaps = 1'b0;

  clamped_piecewise_linear_interp dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .action          (action),
    .point_index     (point_index),
    .point_x         (point_x),
    .point_y         (point_y),
    .query_x         (query_x),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .done            (done),
    .converted_value (converted_value)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int used_points();
    if (active_cfg < 2) return 2;
    if (active_cfg > POINTS) return POINTS;
    return int'(active_cfg);
  endfunction

  function automatic logic signed [DATA_W-1:0] convert_reading(
    logic signed [DATA_W-1:0] q
  );
    int          n;
    longint      x0, x1, y0, dy;
    logic [63:0] dq, dx, mag, quot;
    n = used_points();
    if (q <= bp_x[0]) return bp_y[0];
    if (q >= bp_x[n-1]) return bp_y[n-1];
    for (int i = 0; i + 1 < n; i++) begin
      if (bp_x[i] <= q && q < bp_x[i+1]) begin
        x0 = bp_x[i];
        x1 = bp_x[i+1];
        y0 = bp_y[i];
        dy = longint'(bp_y[i+1]) - y0;
        dq = longint'(q) - x0;
        dx = x1 - x0;
        mag = (dy < 0) ? -dy : dy;
        // exact 64-bit product, quotient truncated, then signed by dy
        quot = (mag * dq) / dx;
        if (dy < 0) return DATA_W'(y0 - longint'(quot));
        return DATA_W'(y0 + longint'(quot));
      end
    end
    return bp_y[n-1];
  endfunction

  // reading drawn to hit clamps, breakpoints and segment interiors
  function automatic logic signed [DATA_W-1:0] pick_reading(int n);
    int          seg;
    longint      lo, hi;
    logic [63:0] span;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return bp_x[$urandom_range(0, n - 1)];
      2: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      3: return DATA_W'(bp_x[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1));
      default: begin
        seg = $urandom_range(0, n - 2);
        lo = bp_x[seg];
        hi = bp_x[seg+1];
        if (hi <= lo) return bp_x[seg];
        span = hi - lo;
        return DATA_W'(lo + longint'({$urandom, $urandom} % span));
      end
    endcase
  endfunction

  task automatic send_beat(input logic act, input logic [IDX_W-1:0] idx,
                           input logic signed [DATA_W-1:0] px,
                           input logic signed [DATA_W-1:0] py,
                           input logic signed [DATA_W-1:0] qx);
    int          gap;
    conversion_t c;
    gap = sender_gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start       <= 1'b1;
    action      <= act;
    point_index <= idx;
    point_x     <= px;
    point_y     <= py;
    query_x     <= qx;
    @(posedge clk);
    while (busy) @(posedge clk);
    // beat taken at this edge
    items_sent++;
    if (act == cpli_pkg::ACT_LOAD) begin
      bp_x[idx] = px;
      bp_y[idx] = py;
    end else begin
      c.reading = qx;
      c.value   = convert_reading(qx);
      pending_conversions.push_back(c);
    end
  endtask

  task automatic send_load(input int idx, input logic signed [DATA_W-1:0] x,
                           input logic signed [DATA_W-1:0] y);
    send_beat(cpli_pkg::ACT_LOAD, IDX_W'(idx), x, y, $urandom);
  endtask

  task automatic send_query(input logic signed [DATA_W-1:0] q);
    send_beat(cpli_pkg::ACT_QUERY, IDX_W'($urandom), $urandom, $urandom, q);
  endtask

  task automatic release_and_drain();
    @(negedge clk) start <= 1'b0;
    while (pending_conversions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_active(input logic [CFG_W-1:0] v);
    release_and_drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk) cfg_we <= 1'b0;
    active_cfg = v;
  endtask

  task automatic note_mismatch(input string what,
                               input logic signed [DATA_W-1:0] reading,
                               input logic signed [DATA_W-1:0] want,
                               input logic signed [DATA_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch (%s): reading %h expected %h got %h", what, reading, want, got);
  endtask

  always @(posedge clk) begin : check_results
    conversion_t want;
    if (!rst && done) begin
      if (pending_conversions.size() == 0) begin
        note_mismatch("unexpected beat", 'x, 'x, converted_value);
      end else begin
        want = pending_conversions.pop_front();
        if (converted_value !== want.value)
          note_mismatch("converted_value", want.reading, want.value, converted_value);
      end
    end
  end

  // full-scale table: every entry written, extreme x at both ends, y swinging rail to rail
  task automatic test_breakpoint_extremes();
    logic signed [DATA_W-1:0] bx;
    sender_gaps = 1'b1;
    for (int i = 0; i < POINTS; i++) begin
      if (i == 0) bx = Q_MIN;
      else if (i == POINTS - 1) bx = Q_MAX;
      else bx = Q_MIN + DATA_W'(i << 28);
      send_load(i, bx, (i % 2 == 0) ? Q_MAX : Q_MIN);
    end
    write_active(5'd31);
    send_query(Q_MIN);
    send_query(Q_MAX);
    send_query(bp_x[7]);
    send_query(bp_x[7] + 1);
    send_query(bp_x[8] - 1);
    send_query(32'sd0);
    send_query(-32'sd1);
  endtask

  // counts below 2 and above the table size, plus the widest possible segment
  task automatic test_active_count_clamp();
    write_active(5'd0);
    send_load(1, Q_MAX, Q_MIN);
    send_query(32'sd0);
    send_query(Q_MAX - 1);
    send_query(Q_MIN + 1);
    write_active(5'd1);
    send_query(32'sh0001_0000);
    // entry 1 now holds Q_MAX like the last entry, so the full table is out of order
    write_active(5'd16);
    send_query(-32'sd1);
    send_query(32'sh1234_5678);
    write_active(5'd17);
    send_query(32'sh7000_0000);
  endtask

  task automatic test_random_tables();
    int                       stop_at, n, shape, span_bits, lo_step, queries;
    logic        [CFG_W-1:0]  v;
    logic signed [DATA_W-1:0] xs [POINTS];
    logic signed [DATA_W-1:0] tmp;
    logic signed [DATA_W-1:0] ys;
    bit                       wide_y;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 7))
        0: v = 5'd0;
        1: v = 5'd2;
        2: v = 5'd16;
        3: v = 5'd31;
        default: v = CFG_W'($urandom_range(0, 31));
      endcase
      write_active(v);
      n = used_points();
      sender_gaps = ($urandom_range(0, 3) != 0);
      shape = $urandom_range(0, 9);
      for (int i = 0; i < n; i++) xs[i] = $urandom;
      if (shape < 4) begin
        for (int i = 0; i < n; i++)
          for (int j = 0; j + 1 < n - i; j++)
            if (xs[j] > xs[j+1]) begin
              tmp = xs[j];
              xs[j] = xs[j+1];
              xs[j+1] = tmp;
            end
      end else if (shape < 8) begin
        // narrow ascending table; shape 7 may repeat an x
        span_bits = $urandom_range(0, 23);
        lo_step = (shape == 7) ? 0 : 1;
        xs[0] = int'($urandom_range(0, 1 << 21)) - (1 << 20);
        for (int i = 1; i < n; i++)
          xs[i] = xs[i-1] + int'($urandom_range(lo_step, 1 << span_bits));
      end
      wide_y = $urandom_range(0, 1);
      for (int i = 0; i < n; i++) begin
        ys = wide_y ? $urandom : int'($urandom_range(0, 1 << 21)) - (1 << 20);
        send_load(i, xs[i], ys);
      end
      queries = $urandom_range(8, 30);
      repeat (queries) begin
        if ($urandom_range(0, 9) == 0)
          send_load($urandom_range(0, POINTS - 1), $urandom, $urandom);
        else
          send_query(pick_reading(n));
        if ($urandom_range(0, 15) == 0) release_and_drain();
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    action      = cpli_pkg::ACT_LOAD;
    point_index = '0;
    point_x     = '0;
    point_y     = '0;
    query_x     = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    active_cfg  = cpli_pkg::ACTIVE_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_breakpoint_extremes();
    test_active_count_clamp();
    test_random_tables();
    release_and_drain();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && pending_conversions.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cpli_pkg.sv
rtl/cpli_ram.sv
rtl/cpli_muldiv.sv
rtl/clamped_piecewise_linear_interp.sv
test/clamped_piecewise_linear_interp_tb.sv
